// ===== src/cml_pkg.sv =====
// Shared types and constants for the coordinate mark list.
`timescale 1ns / 1ps

package cml_pkg;

  localparam int CMD_W = 2;
  localparam int CRD_W = 10;
  localparam int CNT_W = 9;
  localparam int IDX_W = 8;
  localparam int STS_W = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [CRD_W-1:0] coord_x;
    logic [CRD_W-1:0] coord_y;
  } in_req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] live_count;
  } out_rsp_t;

endpackage

// ===== src/cml_store.sv =====
// Mark storage: one write port, one registered read port.
`timescale 1ns / 1ps

module cml_store #(
  parameter int DEPTH = 256,
  parameter int EW    = 20,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/cml_seq.sv =====
// Sequencer: append, linear search and compaction over the mark storage.
`timescale 1ns / 1ps

module cml_seq import cml_pkg::*; #(
  parameter int DEPTH      = 256,
  parameter int COORD_BITS = 10,
  localparam int AW        = $clog2(DEPTH),
  localparam int EW        = 2 * COORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_data,
  input  logic [CNT_W-1:0] cap_i,
  output logic             res_valid,
  input  logic             res_free,
  output out_rsp_t         res_data,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [EW-1:0]    mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  logic [EW-1:0]    mem_rdata
);

  fsm_t             state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [EW-1:0]    mark_r, mark_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] index_r, index_nxt;

  logic             accept;
  logic [EW-1:0]    mark_in;
  logic [CNT_W-1:0] lim;
  logic             room;
  logic             hit;
  logic [CNT_W:0]   cnt_p1;
  logic [CNT_W:0]   cnt_p2;
  logic             last;

  assign accept  = in_valid && in_ready;
  assign mark_in = {COORD_BITS'(in_data.coord_y), COORD_BITS'(in_data.coord_x)};
  assign lim     = (32'(cap_i) > DEPTH) ? CNT_W'(DEPTH) : cap_i;
  assign room    = count_r < lim;
  assign hit     = mem_rdata == mark_r;
  assign cnt_p1  = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign cnt_p2  = {1'b0, cnt_r} + (CNT_W+1)'(2);
  // count is already decremented while shifting, so one compare ends both phases
  assign last    = cnt_p1 >= {1'b0, count_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_data.cmd == CMD_REMOVE || in_data.cmd == CMD_FIND) && count_r != '0) begin
            state_nxt = ST_SEARCH;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_nxt = (cmd_r == CMD_REMOVE && !last) ? ST_SHIFT : ST_DONE;
        end else if (last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(count_r);
    mem_wdata = mark_in;
    mem_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_we   = accept && in_data.cmd == CMD_ADD && room;
      end
      ST_SEARCH: begin
        mem_raddr = AW'(cnt_p1);
      end
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r);
        mem_wdata = mem_rdata;
        mem_raddr = AW'(cnt_p2);
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_nxt    = cmd_r;
    mark_nxt   = mark_r;
    cnt_nxt    = cnt_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    index_nxt  = index_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_data.cmd;
          mark_nxt   = mark_in;
          cnt_nxt    = '0;
          status_nxt = STAT_OK;
          index_nxt  = '0;
          case (in_data.cmd)
            CMD_ADD: begin
              if (room) begin
                index_nxt = count_r;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                status_nxt = STAT_FULL;
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) status_nxt = STAT_EMPTY;
            end
            CMD_FIND: begin
              if (count_r == '0) status_nxt = STAT_MISSING;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          index_nxt = cnt_r;
          if (cmd_r == CMD_REMOVE) count_nxt = count_r - CNT_W'(1);
        end else if (last) begin
          status_nxt = STAT_MISSING;
        end else begin
          cnt_nxt = CNT_W'(cnt_p1);
        end
      end
      ST_SHIFT: begin
        cnt_nxt = CNT_W'(cnt_p1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    mark_r   <= mark_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    index_r  <= index_nxt;
  end

  assign res_data.status      = status_r;
  assign res_data.found_index = IDX_W'(index_r);
  assign res_data.live_count  = count_r;

endmodule

// ===== src/coordinate_mark_list.sv =====
// Packed list of (x,y) grid marks with add, remove and find.
// Flow: add and no-op go straight to the done state; find searches the list in order up to a match
// or the end; remove searches up to the match, then shifts each later entry down one place.
// Throughput: one request in flight; the next is taken once the result is registered.
// Reset: list empty, capacity 256; no clearing pass, entries are written before read.
`timescale 1ns / 1ps

module coordinate_mark_list import cml_pkg::*; #(
  parameter int DEPTH      = 256,
  parameter int COORD_BITS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_rsp_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int EW = 2 * COORD_BITS;

  logic [CNT_W-1:0] cap_r;
  logic             out_valid_r;
  out_rsp_t         out_data_r;

  logic             res_valid;
  logic             res_free;
  out_rsp_t         res_data;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [EW-1:0]    mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [EW-1:0]    mem_rdata;

  assign cfg_ready = 1'b1;
  assign res_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) cap_r <= cfg_data;
      if (res_valid && res_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) out_data_r <= res_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cml_seq #(
    .DEPTH      (DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cap_i     (cap_r),
    .res_valid (res_valid),
    .res_free  (res_free),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cml_store #(
    .DEPTH (DEPTH),
    .EW    (EW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
